// File: hdl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the scheduler table block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hdl/tts_pkg.sv
// ============================================================================
// Scheduler table package
// Types, codes and widths shared by the scheduler table modules.
// ============================================================================
`timescale 1ns / 1ps

package tts_pkg;

   localparam int NumSlotsDefault = 8;
   localparam int MaxOut          = 8;
   localparam int CntW            = $clog2(MaxOut);
   localparam int TagW            = 8;
   localparam int TimeW           = 16;
   localparam int PendW           = 8;
   localparam int SlotW           = 3;
   localparam int ReqDataW        = 48;
   localparam int ReqUserW        = 2;
   localparam int RspDataW        = 16;
   localparam int RspUserW        = 2;

   localparam logic [PendW-1:0] PendMax = '1;

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_ADD      = 2'd1,
      MODE_DELETE   = 2'd2,
      MODE_DISPATCH = 2'd3
   } mode_type;

   typedef struct packed {
      logic [TagW-1:0]  tag;
      logic [TimeW-1:0] delay;
      logic [TimeW-1:0] period;
      logic [PendW-1:0] pending;
   } slot_entry_type;

   typedef struct packed {
      logic load;
      logic del;
      logic step;
      logic finish;
   } tts_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     act;
      logic     idx_last;
      logic     cnt_last;
      logic     need_push;
      logic     out_full;
   } tts_status_type;

endpackage

// File: hdl/tts_ctrl.sv
// ============================================================================
// Scheduler table controller
// Sequences the per-transaction slot walk and the final result.
// ============================================================================
`timescale 1ns / 1ps

module tts_ctrl import tts_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  mode_type       req_mode,
   output logic           req_tready,
   input  tts_status_type status,
   output tts_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_mode == MODE_DELETE) begin
                  cmd.del = 1'b1;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // Hold the current slot while its result cannot be handed off.
            if (!(status.need_push && status.out_full)) begin
               cmd.step = 1'b1;
               if (status.mode == MODE_ADD && status.act) begin
                  state_in = ST_IDLE;
               end else if (status.mode == MODE_DISPATCH && status.act &&
                            status.cnt_last) begin
                  state_in = ST_FINISH;
               end else if (status.idx_last) begin
                  state_in = (status.mode == MODE_TICK) ? ST_IDLE : ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!status.out_full) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/tts_dp.sv
// ============================================================================
// Scheduler table datapath
// Slot memory, valid bits, walk index, held dispatch result, output register.
// ============================================================================
`timescale 1ns / 1ps

module tts_dp import tts_pkg::*; #(
   parameter int NUM_SLOTS = NumSlotsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  tts_cmd_type      cmd,
   output tts_status_type   status,
   input  mode_type         req_mode,
   input  logic [TagW-1:0]  req_task_tag,
   input  logic [TimeW-1:0] req_first_delay,
   input  logic [TimeW-1:0] req_repeat_period,
   input  logic [SlotW-1:0] req_slot,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [SlotW-1:0] rsp_out_slot,
   output logic [TagW-1:0]  rsp_out_tag,
   output logic             rsp_table_full,
   output logic             rsp_none_pending,
   output logic             rsp_last
);

   localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ExtW = IdxW + SlotW;
   localparam logic [IdxW-1:0] IdxLast   = IdxW'(NUM_SLOTS - 1);
   localparam logic [ExtW-1:0] SlotLimit = (ExtW)'(NUM_SLOTS);
   localparam logic [CntW-1:0] CntLast   = CntW'(MaxOut - 1);

   slot_entry_type mem [NUM_SLOTS];
   slot_entry_type rd_ff;
   slot_entry_type wr_data;

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [IdxW-1:0]      idx_ff, idx_in, rd_addr;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   mode_type             mode_ff;
   logic [TagW-1:0]      tag_ff;
   logic [TimeW-1:0]     delay_ff;
   logic [TimeW-1:0]     period_ff;

   logic                 held_valid_ff, held_valid_in;
   logic [SlotW-1:0]     held_slot_ff, held_slot_in;
   logic [TagW-1:0]      held_tag_ff, held_tag_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SlotW-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [TagW-1:0]      rsp_tag_ff, rsp_tag_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic                 rsp_none_ff, rsp_none_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 push;

   logic                 cur_valid, act, idx_last, need_push, rd_en, wr_en;
   logic [ExtW-1:0]      del_ext, cur_ext;
   logic [IdxW-1:0]      del_idx;
   logic [SlotW-1:0]     cur_slot;

   assign del_ext  = {{IdxW{1'b0}}, req_slot};
   assign del_idx  = del_ext[IdxW-1:0];
   assign cur_ext  = {{SlotW{1'b0}}, idx_ff};
   assign cur_slot = cur_ext[SlotW-1:0];
   assign cur_valid = valid_ff[idx_ff];
   assign idx_last  = (idx_ff == IdxLast);

   always_comb begin
      case (mode_ff)
         MODE_TICK:     act = cur_valid;
         MODE_ADD:      act = !cur_valid;
         MODE_DISPATCH: act = cur_valid && (rd_ff.pending != '0);
         default:       act = 1'b0;
      endcase
   end

   assign need_push = ((mode_ff == MODE_ADD) && act) ||
                      ((mode_ff == MODE_DISPATCH) && act && held_valid_ff);

   assign status.mode      = mode_ff;
   assign status.act       = act;
   assign status.idx_last  = idx_last;
   assign status.cnt_last  = (cnt_ff == CntLast);
   assign status.need_push = need_push;
   assign status.out_full  = rsp_valid_ff && !rsp_tready;

   // Updated slot contents for the slot under the walk.
   always_comb begin
      wr_data = rd_ff;
      case (mode_ff)
         MODE_TICK: begin
            if (rd_ff.delay == '0) begin
               if (rd_ff.pending != PendMax) begin
                  wr_data.pending = rd_ff.pending + PendW'(1);
               end
               if (rd_ff.period != '0) begin
                  wr_data.delay = rd_ff.period;
               end
            end else begin
               wr_data.delay = rd_ff.delay - TimeW'(1);
            end
         end
         MODE_ADD: begin
            wr_data.tag     = tag_ff;
            wr_data.delay   = delay_ff;
            wr_data.period  = period_ff;
            wr_data.pending = '0;
         end
         MODE_DISPATCH: begin
            wr_data.pending = rd_ff.pending - PendW'(1);
         end
         default: begin
            wr_data = rd_ff;
         end
      endcase
   end

   assign wr_en   = cmd.step && act;
   assign rd_en   = cmd.load || (cmd.step && !idx_last);
   assign rd_addr = cmd.load ? '0 : idx_ff + IdxW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      held_valid_in = held_valid_ff;
      held_slot_in  = held_slot_ff;
      held_tag_in   = held_tag_ff;
      if (cmd.load) begin
         idx_in        = '0;
         cnt_in        = '0;
         held_valid_in = 1'b0;
      end
      if (cmd.del && (del_ext < SlotLimit)) begin
         valid_in[del_idx] = 1'b0;
      end
      if (cmd.step) begin
         idx_in = idx_last ? idx_ff : idx_ff + IdxW'(1);
         if (act && (mode_ff == MODE_ADD)) begin
            valid_in[idx_ff] = 1'b1;
         end
         if (act && (mode_ff == MODE_DISPATCH)) begin
            cnt_in        = cnt_ff + CntW'(1);
            held_valid_in = 1'b1;
            held_slot_in  = cur_slot;
            held_tag_in   = rd_ff.tag;
            if (rd_ff.period == '0) begin
               valid_in[idx_ff] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      push        = 1'b0;
      rsp_slot_in = rsp_slot_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_full_in = rsp_full_ff;
      rsp_none_in = rsp_none_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.step && need_push) begin
         push = 1'b1;
         rsp_full_in = 1'b0;
         rsp_none_in = 1'b0;
         if (mode_ff == MODE_ADD) begin
            rsp_slot_in = cur_slot;
            rsp_tag_in  = '0;
            rsp_last_in = 1'b1;
         end else begin
            rsp_slot_in = held_slot_ff;
            rsp_tag_in  = held_tag_ff;
            rsp_last_in = 1'b0;
         end
      end else if (cmd.finish) begin
         push        = 1'b1;
         rsp_last_in = 1'b1;
         rsp_slot_in = '0;
         rsp_tag_in  = '0;
         rsp_full_in = 1'b0;
         rsp_none_in = 1'b0;
         if (mode_ff == MODE_ADD) begin
            rsp_full_in = 1'b1;
         end else if (held_valid_ff) begin
            rsp_slot_in = held_slot_ff;
            rsp_tag_in  = held_tag_ff;
         end else begin
            rsp_none_in = 1'b1;
         end
      end
      rsp_valid_in = push ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_TICK;
      end else begin
         valid_ff      <= valid_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cmd.load) begin
            mode_ff <= req_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_ff    <= req_task_tag;
         delay_ff  <= req_first_delay;
         period_ff <= req_repeat_period;
      end
      held_slot_ff <= held_slot_in;
      held_tag_ff  <= held_tag_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_out_slot     = rsp_slot_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_none_pending = rsp_none_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// File: hdl/tick_task_scheduler_table_unit.sv
// ============================================================================
// Tick task scheduler table
// Time-triggered cooperative scheduler: a table of task slots driven by tick,
// add, delete and dispatch transactions.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A tick, add or dispatch transaction walks the slot table one slot per clock
// through a single-read, single-write slot memory; a delete needs no walk.
// An add stops early at the first free slot, and a dispatch stops after eight
// served slots. A walk pauses while a result is ready to leave but the output
// register is still occupied, so a slow consumer stretches a transaction. New
// transactions are accepted while an earlier result still waits in the output
// register. Results come out in slot order; tlast marks the final result of
// each transaction. Tick and delete transactions produce no result. Every slot
// is free after reset.

module tick_task_scheduler_table_unit import tts_pkg::*; #(
   parameter int NUM_SLOTS = NumSlotsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // task_tag[7:0], first_delay[23:8], repeat_period[39:24], slot[42:40],
   // zero fill above.
   input  logic [ReqDataW-1:0] req_tdata,
   // mode[1:0].
   input  logic [ReqUserW-1:0] req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // out_slot[2:0], out_tag[10:3], zero fill above.
   output logic [RspDataW-1:0] rsp_tdata,
   // table_full[0], none_pending[1].
   output logic [RspUserW-1:0] rsp_tuser,
   output logic                rsp_tlast
);

   tts_cmd_type    cmd;
   tts_status_type status;
   mode_type       req_mode;
   logic [SlotW-1:0] rsp_out_slot;
   logic [TagW-1:0]  rsp_out_tag;
   logic             rsp_table_full;
   logic             rsp_none_pending;

   assign req_mode = mode_type'(req_tuser);

   // The controller owns the handshake toward the requester and the walk
   // sequence; all slot state lives in the datapath.
   tts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_mode),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tts_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_task_tag      (req_tdata[7:0]),
      .req_first_delay   (req_tdata[23:8]),
      .req_repeat_period (req_tdata[39:24]),
      .req_slot          (req_tdata[42:40]),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_out_slot      (rsp_out_slot),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_table_full    (rsp_table_full),
      .rsp_none_pending  (rsp_none_pending),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {{(RspDataW - SlotW - TagW){1'b0}}, rsp_out_tag, rsp_out_slot};
   assign rsp_tuser = {rsp_none_pending, rsp_table_full};

   // A result is never both a full-table report and an empty dispatch.
   `ASSERT_IMPL(a_flags_exclusive, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))

   // A full-table report is a lone, final result naming slot zero.
   `ASSERT_IMPL(a_full_shape, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast && (rsp_tdata == '0))

   // An empty dispatch report is a lone, final result with no slot or tag.
   `ASSERT_IMPL(a_none_shape, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast && (rsp_tdata == '0))

   // A delete completes in its own cycle and never starts a walk.
   `ASSERT_NEXT(a_delete_quick, clock, reset, req_tvalid && req_tready && (req_mode == MODE_DELETE), req_tready)

endmodule
